FILE: design/smrv_pkg.sv
// Package for the sparse matrix maximum row variance core.
// Holds field widths, default parameter values and the accumulator control type.
// Used by every module in the design folder.
package smrv_pkg;

  localparam int VALUE_W = 24;
  localparam int NUM_COLS_W = 17;
  localparam int SUM_W = 41;
  localparam int SQS_W = 64;
  localparam int SQ_W = 2 * SUM_W;
  localparam int VAR_W = 47;

  localparam int DEF_MAX_COLUMNS = 65536;
  localparam int DEF_VALUE_BITS = 24;

  typedef struct packed {
    logic load;
    logic add;
    logic clear;
  } acc_ctl_t;

endpackage

FILE: design/smrv_accum.sv
// Row accumulators: saturating sum and sum of squares of the incoming values.
// Squares one value per transaction with a single registered multiplier.
// Depends on smrv_pkg.
module smrv_accum #(
  parameter int VALUE_BITS = smrv_pkg::DEF_VALUE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  smrv_pkg::acc_ctl_t                     ctl,
  input  logic signed [smrv_pkg::VALUE_W-1:0]    value,
  output logic signed [smrv_pkg::SUM_W-1:0]      row_sum,
  output logic        [smrv_pkg::SQS_W-1:0]      row_sum_squares,
  output logic                                   overflow_mark
);
  import smrv_pkg::*;

  localparam int SHIFT = VALUE_W - VALUE_BITS;

  logic signed [VALUE_W-1:0]   vsh;
  logic signed [VALUE_W-1:0]   xs;
  logic        [VALUE_W-1:0]   ax;
  logic        [2*VALUE_W-1:0] sq_in;
  logic signed [VALUE_W-1:0]   x;
  logic        [2*VALUE_W-1:0] sq;
  logic signed [SUM_W:0]       ns;
  logic        [SQS_W:0]       ss;

  always_comb begin
    vsh = value <<< SHIFT;
    xs = vsh >>> SHIFT;
    ax = xs[VALUE_W-1] ? VALUE_W'(-xs) : VALUE_W'(xs);
    sq_in = ax * ax;
    ns = (SUM_W+1)'(row_sum) + (SUM_W+1)'(x);
    ss = {1'b0, row_sum_squares} + (SQS_W+1)'(sq);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= xs;
      sq <= sq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row_sum <= '0;
      row_sum_squares <= '0;
      overflow_mark <= 1'b0;
    end else if (ctl.add) begin
      if (ns[SUM_W] != ns[SUM_W-1]) begin
        row_sum <= ns[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        row_sum <= ns[SUM_W-1:0];
      end
      if (ss[SQS_W]) begin
        row_sum_squares <= '1;
      end else begin
        row_sum_squares <= ss[SQS_W-1:0];
      end
      overflow_mark <= overflow_mark || (ns[SUM_W] != ns[SUM_W-1]) || ss[SQS_W];
    end
  end

endmodule

FILE: design/smrv_sqr.sv
// Iterative shift-and-add squarer, one multiplier bit per cycle.
// Squares the magnitude of the row sum for the variance calculation.
// Depends on smrv_pkg.
module smrv_sqr (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [smrv_pkg::SUM_W-1:0]  a,
  output logic                        done,
  output logic [smrv_pkg::SQ_W-1:0]   prod
);
  import smrv_pkg::*;

  localparam int CW = $clog2(SUM_W);
  localparam logic [CW-1:0] LAST = CW'(SUM_W - 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [SUM_W-1:0] areg;
  logic [SUM_W-1:0] mreg;
  logic [SQ_W-1:0]  prod_next;

  always_comb begin
    prod_next = {prod[SQ_W-2:0], 1'b0} + (mreg[SUM_W-1] ? SQ_W'(areg) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      mreg <= a;
      prod <= '0;
    end else if (busy) begin
      prod <= prod_next;
      mreg <= {mreg[SUM_W-2:0], 1'b0};
    end
  end

endmodule

FILE: design/smrv_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions by N.
// Divides a wide unsigned dividend by the clamped column count.
// Depends on smrv_pkg.
module smrv_div #(
  parameter int NW = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [smrv_pkg::SQ_W-1:0]  dividend,
  input  logic [NW-1:0]              divisor,
  output logic                       done,
  output logic [smrv_pkg::SQ_W-1:0]  quotient
);
  import smrv_pkg::*;

  localparam int CW = $clog2(SQ_W);
  localparam logic [CW-1:0] LAST = CW'(SQ_W - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW:0]   rs;
  logic          ge;

  always_comb begin
    rs = {rem, quotient[SQ_W-1]};
    ge = rs >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem <= ge ? NW'(rs - {1'b0, divisor}) : NW'(rs);
      quotient <= {quotient[SQ_W-2:0], ge};
    end
  end

endmodule

FILE: design/sparse_max_row_variance_core.sv
// Sparse matrix maximum row variance core; uses smrv_pkg, smrv_accum, smrv_sqr, smrv_div.
// An entry that does not end a row goes via S_ACC back to S_IDLE to accept the next entry.
// A row-ending entry runs a 41-step squarer and then two 82-step divisions by N in turn;
// the result is loaded into the output register from S_DONE once the output is not stalled.
// The next entry is accepted while a result waits; the next row end waits for that result.
// Synchronous reset clears the sums, the maximum, the state and sets the column count to 1.
module sparse_max_row_variance_core #(
  parameter int MAX_COLUMNS = smrv_pkg::DEF_MAX_COLUMNS,
  parameter int VALUE_BITS = smrv_pkg::DEF_VALUE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [smrv_pkg::NUM_COLS_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [smrv_pkg::VALUE_W-1:0]  value,
  input  logic                                 row_end,
  input  logic                                 matrix_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [smrv_pkg::VAR_W-1:0]           row_variance,
  output logic [smrv_pkg::VAR_W-1:0]           max_variance,
  output logic                                 is_final,
  output logic                                 saturated
);
  import smrv_pkg::*;

  localparam int NW = $clog2(MAX_COLUMNS + 1);
  localparam logic [NUM_COLS_W-1:0] MAX_N = NUM_COLS_W'(MAX_COLUMNS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_ACC  = 8'b00000010,
    S_SQS  = 8'b00000100,
    S_SQW  = 8'b00001000,
    S_D1W  = 8'b00010000,
    S_DIFF = 8'b00100000,
    S_D2W  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [NUM_COLS_W-1:0] num_cols;
  logic [NUM_COLS_W-1:0] n_clamp;
  logic [NW-1:0]         n;
  logic                  end_row;
  logic                  fin;
  logic [VAR_W-1:0]      running_max;
  logic [SQS_W-1:0]      d;
  logic [SQS_W-1:0]      d_next;
  logic [SQS_W-1:0]      q64;
  logic [VAR_W-1:0]      var_sat;
  logic [VAR_W-1:0]      max_next;
  logic                  in_acc;
  logic                  out_load;

  acc_ctl_t              acc_ctl;
  logic signed [SUM_W-1:0] row_sum;
  logic [SQS_W-1:0]      row_sum_squares;
  logic                  overflow_mark;
  logic [SUM_W-1:0]      a_mag;

  logic                  sqr_start;
  logic                  sqr_done;
  logic [SQ_W-1:0]       sqr_prod;
  logic                  div_start;
  logic                  div_done;
  logic [SQ_W-1:0]       div_in;
  logic [SQ_W-1:0]       div_q;

  smrv_accum #(.VALUE_BITS(VALUE_BITS)) u_accum (
    .clk             (clk),
    .rst             (rst),
    .ctl             (acc_ctl),
    .value           (value),
    .row_sum         (row_sum),
    .row_sum_squares (row_sum_squares),
    .overflow_mark   (overflow_mark)
  );

  smrv_sqr u_sqr (
    .clk   (clk),
    .rst   (rst),
    .start (sqr_start),
    .a     (a_mag),
    .done  (sqr_done),
    .prod  (sqr_prod)
  );

  smrv_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    in_stall = (state != S_IDLE);
    in_acc = in_valid && !in_stall;
    out_load = (state == S_DONE) && (!out_valid || !out_stall);

    if (num_cols == '0) begin
      n_clamp = NUM_COLS_W'(1);
    end else if (num_cols > MAX_N) begin
      n_clamp = MAX_N;
    end else begin
      n_clamp = num_cols;
    end
    n = NW'(n_clamp);

    a_mag = row_sum[SUM_W-1] ? SUM_W'(-row_sum) : SUM_W'(row_sum);

    q64 = (|div_q[SQ_W-1:SQS_W]) ? '1 : div_q[SQS_W-1:0];
    d_next = (row_sum_squares > q64) ? row_sum_squares - q64 : '0;
    var_sat = (|div_q[SQ_W-1:VAR_W]) ? '1 : div_q[VAR_W-1:0];
    max_next = (var_sat > running_max) ? var_sat : running_max;

    acc_ctl.load = in_acc;
    acc_ctl.add = (state == S_ACC);
    acc_ctl.clear = out_load;

    sqr_start = (state == S_SQS);
    div_start = ((state == S_SQW) && sqr_done) || (state == S_DIFF);
    div_in = (state == S_DIFF) ? SQ_W'(d) : sqr_prod;

    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        state_next = end_row ? S_SQS : S_IDLE;
      end
      S_SQS: begin
        state_next = S_SQW;
      end
      S_SQW: begin
        if (sqr_done) begin
          state_next = S_D1W;
        end
      end
      S_D1W: begin
        if (div_done) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        state_next = S_D2W;
      end
      S_D2W: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_cols <= NUM_COLS_W'(1);
      running_max <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_cols <= cfg_wdata;
      end
      if (out_load) begin
        running_max <= fin ? '0 : max_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      end_row <= row_end || matrix_end;
      fin <= matrix_end;
    end
    if ((state == S_D1W) && div_done) begin
      d <= d_next;
    end
    if (out_load) begin
      row_variance <= var_sat;
      max_variance <= max_next;
      is_final <= fin;
      saturated <= overflow_mark;
    end
  end

endmodule
